@@ rtl/pidl_pkg.sv @@
`default_nettype none

package pidl_pkg;

	// Wide enough for a slot number or an entry count at the largest supported depth.
	localparam int SLOT_W = 7;

	typedef enum logic [2:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_BACK  = 3'd1,
		CMD_INS_POS   = 3'd2,
		CMD_DEL_FRONT = 3'd3,
		CMD_DEL_BACK  = 3'd4,
		CMD_DEL_POS   = 3'd5,
		CMD_READ_OUT  = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [SLOT_W-1:0]   slot;
	} cell_ctrl_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] value;
		logic [4:0]  position;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic        data_valid;
		logic [31:0] element;
		logic [4:0]  entry_count;
		logic        last_result;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/pidl_cell.sv @@
`default_nettype none

module pidl_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int INDEX      = 0
) (
	input  wire logic                  clk,
	input  wire pidl_pkg::cell_ctrl_t  ctrl,
	input  wire logic [DATA_WIDTH-1:0] bcast,
	input  wire logic [DATA_WIDTH-1:0] left,
	input  wire logic [DATA_WIDTH-1:0] right,
	output logic      [DATA_WIDTH-1:0] data
);

	localparam int SW = pidl_pkg::SLOT_W;
	localparam logic [SW-1:0] MY_SLOT = SW'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;

	// Each cell decides from the shared command and its own place in the row
	// whether it holds, takes a neighbour's word or takes the broadcast word.
	always_comb begin
		data_d = data_q;
		case (ctrl.op)
			pidl_pkg::OP_INSERT: begin
				if (MY_SLOT > ctrl.slot) begin
					data_d = left;
				end else if (MY_SLOT == ctrl.slot) begin
					data_d = bcast;
				end
			end
			pidl_pkg::OP_DELETE: begin
				if (MY_SLOT >= ctrl.slot) begin
					data_d = right;
				end
			end
			pidl_pkg::OP_ROTATE: begin
				if (MY_SLOT < ctrl.slot) begin
					data_d = right;
				end else if (MY_SLOT == ctrl.slot) begin
					data_d = bcast;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

`default_nettype wire

@@ rtl/positional_insert_delete_list_core.sv @@
`default_nettype none

// Bounded ordered list of data words with positional insert and delete.
// A command beat is taken at a rising edge where start is high and busy is low.
// It inserts at the front, the back or a 1-based position, deletes the front,
// the back or a position, or reads the whole list out in order.
// Every command except a read-out of a non-empty list gives one result beat in
// the cycle after it is taken, with last_result set. A read-out of N entries
// gives N beats on consecutive cycles starting in the cycle after the command,
// the last one flagged; busy stays high until the final beat has been loaded.
// Inserts and deletes therefore run at one command per cycle, and a read-out
// occupies the block while the row of cells rotates one word per cycle past
// the head cell.
// Each result beat is shown for exactly one cycle with result_valid high; the
// receiver has no way to hold it off, so it must take every beat as it comes.
// Reset empties the list and clears the strobe; the cell contents are left as
// they are, since only entries below the fill count are ever read.
module positional_insert_delete_list_core #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire pidl_pkg::request_t request,
	output logic                    result_valid,
	output pidl_pkg::result_t       result
);

	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMP_W = ((CW > 5) ? CW : 5) + 1;
	localparam int SW    = pidl_pkg::SLOT_W;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       occ_q;
	logic [CW-1:0]       rd_cnt_q;
	logic                result_valid_q;
	pidl_pkg::result_t   result_q;

	logic                    accept;
	pidl_pkg::cell_ctrl_t    ctrl;
	pidl_pkg::status_t       status_d;
	logic [CW-1:0]           occ_d;
	logic [DATA_WIDTH-1:0]   bcast;
	logic [DATA_WIDTH-1:0]   head;
	logic [CW-1:0]           occ_last;
	logic [CMP_W-1:0]        pos_ext;
	logic [CMP_W-1:0]        occ_ext;
	logic                    full;

	logic [DATA_WIDTH-1:0]   cell_data [DEPTH];
	logic [DATA_WIDTH-1:0]   left_in   [DEPTH];
	logic [DATA_WIDTH-1:0]   right_in  [DEPTH];

	assign busy         = (state_q == S_READ);
	assign accept       = start && !busy;
	assign head         = cell_data[0];
	assign occ_last     = occ_q - CW'(1);
	assign pos_ext      = CMP_W'(request.position);
	assign occ_ext      = CMP_W'(occ_q);
	assign full         = (occ_q == CW'(DEPTH));
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Command decode: one shift command to the whole row of cells per cycle.
	always_comb begin
		ctrl     = '{op: pidl_pkg::OP_HOLD, slot: '0};
		status_d = pidl_pkg::ST_DONE;
		occ_d    = occ_q;
		bcast    = DATA_WIDTH'(request.value);
		if (state_q == S_READ) begin
			ctrl  = '{op: pidl_pkg::OP_ROTATE, slot: SW'(occ_last)};
			bcast = head;
		end else if (accept) begin
			case (request.command)
				pidl_pkg::CMD_INS_FRONT, pidl_pkg::CMD_INS_BACK: begin
					if (full) begin
						status_d = pidl_pkg::ST_FULL;
					end else begin
						ctrl.op   = pidl_pkg::OP_INSERT;
						ctrl.slot = (request.command == pidl_pkg::CMD_INS_FRONT) ?
							'0 : SW'(occ_q);
						occ_d     = occ_q + CW'(1);
					end
				end
				pidl_pkg::CMD_INS_POS: begin
					// The position check takes precedence over the full check.
					if (pos_ext == '0 || pos_ext > occ_ext + CMP_W'(1)) begin
						status_d = pidl_pkg::ST_INVALID;
					end else if (full) begin
						status_d = pidl_pkg::ST_FULL;
					end else begin
						ctrl.op   = pidl_pkg::OP_INSERT;
						ctrl.slot = SW'(pos_ext - CMP_W'(1));
						occ_d     = occ_q + CW'(1);
					end
				end
				pidl_pkg::CMD_DEL_FRONT, pidl_pkg::CMD_DEL_BACK: begin
					if (occ_q == '0) begin
						status_d = pidl_pkg::ST_INVALID;
					end else begin
						ctrl.op   = pidl_pkg::OP_DELETE;
						ctrl.slot = (request.command == pidl_pkg::CMD_DEL_FRONT) ?
							'0 : SW'(occ_last);
						occ_d     = occ_last;
					end
				end
				pidl_pkg::CMD_DEL_POS: begin
					if (pos_ext == '0 || pos_ext > occ_ext) begin
						status_d = pidl_pkg::ST_INVALID;
					end else begin
						ctrl.op   = pidl_pkg::OP_DELETE;
						ctrl.slot = SW'(pos_ext - CMP_W'(1));
						occ_d     = occ_last;
					end
				end
				pidl_pkg::CMD_READ_OUT: begin
					// The row rotates once per emitted word, so after a full
					// read-out every word is back in its original cell.
					if (occ_q != '0) begin
						ctrl  = '{op: pidl_pkg::OP_ROTATE, slot: SW'(occ_last)};
						bcast = head;
					end
				end
				default: begin
					status_d = pidl_pkg::ST_INVALID;
				end
			endcase
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_in[i] = bcast;
		end else begin : g_mid
			assign left_in[i] = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_in[i] = cell_data[i];
		end else begin : g_inner
			assign right_in[i] = cell_data[i+1];
		end

		pidl_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.INDEX      (i)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.bcast (bcast),
			.left  (left_in[i]),
			.right (right_in[i]),
			.data  (cell_data[i])
		);
	end

	// Sequencer for the read-out stream, the fill count and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			occ_q          <= '0;
			rd_cnt_q       <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						result_valid_q <= 1'b1;
						occ_q          <= occ_d;
						if (request.command == pidl_pkg::CMD_READ_OUT && occ_q != '0) begin
							result_q <= '{status:      pidl_pkg::ST_DONE,
							              data_valid:  1'b1,
							              element:     32'(head),
							              entry_count: 5'(occ_q),
							              last_result: (occ_q == CW'(1))};
							rd_cnt_q <= CW'(1);
							if (occ_q != CW'(1)) begin
								state_q <= S_READ;
							end
						end else begin
							result_q <= '{status:      status_d,
							              data_valid:  1'b0,
							              element:     '0,
							              entry_count: 5'(occ_d),
							              last_result: 1'b1};
						end
					end
				end
				S_READ: begin
					result_valid_q <= 1'b1;
					result_q <= '{status:      pidl_pkg::ST_DONE,
					              data_valid:  1'b1,
					              element:     32'(head),
					              entry_count: 5'(occ_q),
					              last_result: (rd_cnt_q == occ_last)};
					rd_cnt_q <= rd_cnt_q + CW'(1);
					if (rd_cnt_q == occ_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/pidl_checker.sv @@
`default_nettype none

module pidl_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               result_valid,
	input wire pidl_pkg::result_t  result
);

	// Every accepted command shows its first result beat in the next cycle.
	a_first_beat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> result_valid)
		else $error("accepted command gave no result beat");

	// While a read-out is streaming, a non-final beat is on the result port.
	a_busy_streams: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> result_valid && !result.last_result)
		else $error("busy without a streaming read-out beat");

	// A read-out stream has no gaps and keeps the same entry count.
	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_result |=>
			result_valid && result.data_valid &&
			result.entry_count == $past(result.entry_count))
		else $error("read-out stream broke or changed its count");

	// A beat without data always ends its command.
	a_nodata_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.data_valid |-> result.last_result)
		else $error("beat without data not flagged last");

	// Data beats only ever carry a done status.
	a_data_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.data_valid |-> result.status == pidl_pkg::ST_DONE)
		else $error("data beat with a failure status");

endmodule

bind positional_insert_delete_list_core pidl_checker u_pidl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire
